// ===== rtl/srq_pkg.sv =====
package srq_pkg;

    localparam int SRQ_W             = 32;
    localparam int SRQ_OUT_FRAC_BITS = 30;
    localparam int SRQ_GUARD         = 30;
    localparam int SRQ_LANES         = 4;

    typedef struct packed {
        logic signed [SRQ_W-1:0] r00;
        logic signed [SRQ_W-1:0] r01;
        logic signed [SRQ_W-1:0] r02;
        logic signed [SRQ_W-1:0] r10;
        logic signed [SRQ_W-1:0] r11;
        logic signed [SRQ_W-1:0] r12;
        logic signed [SRQ_W-1:0] r20;
        logic signed [SRQ_W-1:0] r21;
        logic signed [SRQ_W-1:0] r22;
    } t_srq_in;

    typedef struct packed {
        logic signed [SRQ_W-1:0] quat_real;
        logic signed [SRQ_W-1:0] quat_i;
        logic signed [SRQ_W-1:0] quat_j;
        logic signed [SRQ_W-1:0] quat_k;
        logic                    degenerate;
    } t_srq_out;

endpackage

// ===== rtl/scaled_rotation_to_quaternion_top.sv =====
// channel   direction  handshake            word
// input     in         i_valid / o_stall    i_data  (nine Q8.24 matrix entries)
// output    out        o_valid / i_stall    o_data  (quaternion Q2.30, degenerate flag)
//
// one word accepted per cycle while o_stall is low, one result word per input word, in order
// the pipeline holds the row-length root of 32 stages, the product root of 63 stages,
//   the divider of 33 stages, plus arithmetic stages and the output register
// reset clears the valid bits of every stage, the output register and the skid
// a stalled output parks one word in the skid; the pipeline freezes only while it is full
module scaled_rotation_to_quaternion_top #(
    parameter int OUT_FRAC_BITS = srq_pkg::SRQ_OUT_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  srq_pkg::t_srq_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output srq_pkg::t_srq_out o_data
);
    import srq_pkg::*;

    localparam int SQW   = 2 * SRQ_W;          // square of one entry
    localparam int CW    = SRQ_W + 3;          // candidates
    localparam int OW    = SRQ_W + 1;          // off-diagonal sums
    localparam int MW    = SRQ_W + 2;          // largest candidate / numerator magnitude
    localparam int HALF  = MW / 2;             // split of M for the product
    localparam int PPW   = MW - HALF + SRQ_W;  // partial product width
    localparam int PRODW = MW + SRQ_W;         // M * s
    localparam int RADW  = PRODW + 2 * SRQ_GUARD;
    localparam int RTW   = RADW / 2;
    localparam int DW    = RTW + 1;
    localparam int SHIFT = SRQ_GUARD + OUT_FRAC_BITS;
    localparam int NW    = MW + SHIFT + 1;

    typedef enum logic [1:0] {LEAD_W, LEAD_X, LEAD_Y, LEAD_Z} t_lead;

    typedef struct packed {
        logic                            deg;
        logic [SRQ_LANES-1:0]            neg;
        logic [SRQ_LANES-1:0][MW-1:0]    mag;
    } t_rt_side;

    typedef struct packed {
        logic                 deg;
        logic [SRQ_LANES-1:0] neg;
    } t_dv_side;

    // pipeline advances unless the skid holds a word
    logic r_skid_vld;
    logic en;
    assign en = !r_skid_vld;

    // stage a: entry squares
    logic               r_a_vld;
    t_srq_in            r_a_m;
    logic [SQW-1:0]     r_a_sq [3];
    // stage b: row length squared
    logic               r_b_vld;
    t_srq_in            r_b_m;
    logic [SQW-1:0]     r_b_sum;

    function automatic logic [SRQ_W-1:0] mag32(input logic signed [SRQ_W-1:0] x);
        return x[SRQ_W-1] ? SRQ_W'(-x) : x;
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_m     <= i_data;
            r_a_sq[0] <= SQW'(mag32(i_data.r00)) * SQW'(mag32(i_data.r00));
            r_a_sq[1] <= SQW'(mag32(i_data.r01)) * SQW'(mag32(i_data.r01));
            r_a_sq[2] <= SQW'(mag32(i_data.r02)) * SQW'(mag32(i_data.r02));
            r_b_m     <= r_a_m;
            r_b_sum   <= r_a_sq[0] + r_a_sq[1] + r_a_sq[2];
        end
    end

    // scale s = floor sqrt of the row length squared
    logic             w_s_vld;
    logic [SRQ_W-1:0] w_s_root;
    t_srq_in          w_s_m;

    srq_sqrt #(
        .VW (SQW),
        .SW ($bits(t_srq_in))
    ) u_sqrt_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_vld),
        .i_rad   (r_b_sum),
        .i_side  (r_b_m),
        .o_valid (w_s_vld),
        .o_root  (w_s_root),
        .o_side  (w_s_m)
    );

    // stage c: candidates and off-diagonal sums
    logic                 r_c_vld;
    logic [SRQ_W-1:0]     r_c_s;
    logic                 r_c_deg;
    logic signed [CW-1:0] r_c_cand [SRQ_LANES];
    logic signed [OW-1:0] r_c_off  [6];

    always_ff @(posedge i_clk) begin
        logic signed [CW-1:0] s_ext;
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
        s_ext = $signed({3'b000, w_s_root});
        a     = CW'(w_s_m.r00);
        b     = CW'(w_s_m.r11);
        c     = CW'(w_s_m.r22);
        if (en) begin
            r_c_s       <= w_s_root;
            r_c_deg     <= (w_s_root == '0);
            r_c_cand[0] <= s_ext + a + b + c;
            r_c_cand[1] <= s_ext + a - b - c;
            r_c_cand[2] <= s_ext - a + b - c;
            r_c_cand[3] <= s_ext - a - b + c;
            r_c_off[0]  <= OW'(w_s_m.r21) - OW'(w_s_m.r12);
            r_c_off[1]  <= OW'(w_s_m.r02) - OW'(w_s_m.r20);
            r_c_off[2]  <= OW'(w_s_m.r10) - OW'(w_s_m.r01);
            r_c_off[3]  <= OW'(w_s_m.r10) + OW'(w_s_m.r01);
            r_c_off[4]  <= OW'(w_s_m.r02) + OW'(w_s_m.r20);
            r_c_off[5]  <= OW'(w_s_m.r21) + OW'(w_s_m.r12);
        end
    end

    // stage d: pick the leading component, earliest wins on a tie
    logic                 r_d_vld;
    logic [SRQ_W-1:0]     r_d_s;
    logic                 r_d_deg;
    logic [MW-1:0]        r_d_m;
    logic signed [CW-1:0] r_d_n [SRQ_LANES];

    t_lead                lead01;
    t_lead                lead23;
    t_lead                lead;
    logic signed [CW-1:0] n_n [SRQ_LANES];

    always_comb begin
        logic signed [CW-1:0] o0;
        logic signed [CW-1:0] o1;
        logic signed [CW-1:0] o2;
        logic signed [CW-1:0] o3;
        logic signed [CW-1:0] o4;
        logic signed [CW-1:0] o5;
        o0     = CW'(r_c_off[0]);
        o1     = CW'(r_c_off[1]);
        o2     = CW'(r_c_off[2]);
        o3     = CW'(r_c_off[3]);
        o4     = CW'(r_c_off[4]);
        o5     = CW'(r_c_off[5]);
        lead01 = (r_c_cand[1] > r_c_cand[0]) ? LEAD_X : LEAD_W;
        lead23 = (r_c_cand[3] > r_c_cand[2]) ? LEAD_Z : LEAD_Y;
        lead   = (r_c_cand[lead23] > r_c_cand[lead01]) ? lead23 : lead01;
        unique case (lead)
            LEAD_W: begin
                n_n[0] = r_c_cand[0]; n_n[1] = o0; n_n[2] = o1; n_n[3] = o2;
            end
            LEAD_X: begin
                n_n[0] = o0; n_n[1] = r_c_cand[1]; n_n[2] = o3; n_n[3] = o4;
            end
            LEAD_Y: begin
                n_n[0] = o1; n_n[1] = o3; n_n[2] = r_c_cand[2]; n_n[3] = o5;
            end
            LEAD_Z: begin
                n_n[0] = o2; n_n[1] = o4; n_n[2] = o5; n_n[3] = r_c_cand[3];
            end
            default: begin
                n_n[0] = '0; n_n[1] = '0; n_n[2] = '0; n_n[3] = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_s   <= r_c_s;
            r_d_deg <= r_c_deg;
            r_d_m   <= r_c_cand[lead][MW-1:0];
            r_d_n   <= n_n;
        end
    end

    // stage e: partial products of M * s, signs and magnitudes
    logic           r_e_vld;
    logic [PPW-1:0] r_e_pl;
    logic [PPW-1:0] r_e_ph;
    t_rt_side       r_e_side;

    always_ff @(posedge i_clk) begin
        logic signed [CW-1:0] a;
        a = '0;
        if (en) begin
            r_e_pl       <= PPW'(r_d_m[HALF-1:0]) * PPW'(r_d_s);
            r_e_ph       <= PPW'(r_d_m[MW-1:HALF]) * PPW'(r_d_s);
            r_e_side.deg <= r_d_deg;
            for (int l = 0; l < SRQ_LANES; l++) begin
                a                = r_d_n[l][CW-1] ? -r_d_n[l] : r_d_n[l];
                // real part is given negated
                r_e_side.neg[l] <= r_d_n[l][CW-1] ^ (l == 0);
                r_e_side.mag[l] <= a[MW-1:0];
            end
        end
    end

    // stage f: radicand M * s * 2^(2*guard)
    logic            r_f_vld;
    logic [RADW-1:0] r_f_rad;
    t_rt_side        r_f_side;

    always_ff @(posedge i_clk) begin
        logic [PRODW-1:0] prod;
        prod = (PRODW'(r_e_ph) << HALF) + PRODW'(r_e_pl);
        if (en) begin
            r_f_rad  <= RADW'(prod) << (2 * SRQ_GUARD);
            r_f_side <= r_e_side;
        end
    end

    logic           w_r_vld;
    logic [RTW-1:0] w_r_root;
    t_rt_side       w_r_side;

    srq_sqrt #(
        .VW (RADW),
        .SW ($bits(t_rt_side))
    ) u_sqrt_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f_vld),
        .i_rad   (r_f_rad),
        .i_side  (r_f_side),
        .o_valid (w_r_vld),
        .o_root  (w_r_root),
        .o_side  (w_r_side)
    );

    // stage g: numerators |N| * 2^shift + R for rounding, divisor 2R
    logic                         r_g_vld;
    logic [SRQ_LANES-1:0][NW-1:0] r_g_num;
    logic [DW-1:0]                r_g_den;
    t_dv_side                     r_g_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < SRQ_LANES; l++) begin
                r_g_num[l] <= (NW'(w_r_side.mag[l]) << SHIFT) + NW'(w_r_root);
            end
            r_g_den      <= {w_r_root, 1'b0};
            r_g_side.deg <= w_r_side.deg;
            r_g_side.neg <= w_r_side.neg;
        end
    end

    logic                            w_q_vld;
    logic [SRQ_LANES-1:0][SRQ_W-1:0] w_q_quo;
    logic [SRQ_LANES-1:0]            w_q_ovf;
    t_dv_side                        w_q_side;

    srq_div #(
        .NW (NW),
        .DW (DW),
        .SW ($bits(t_dv_side))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_g_vld),
        .i_num   (r_g_num),
        .i_den   (r_g_den),
        .i_side  (r_g_side),
        .o_valid (w_q_vld),
        .o_quo   (w_q_quo),
        .o_ovf   (w_q_ovf),
        .o_side  (w_q_side)
    );

    // saturate, apply sign, identity on a zero first row
    t_srq_out p_data;

    always_comb begin
        logic [SRQ_W-1:0] lim;
        logic [SRQ_W-1:0] v;
        logic [SRQ_W-1:0] q [SRQ_LANES];
        lim = '0;
        v   = '0;
        for (int l = 0; l < SRQ_LANES; l++) begin
            lim  = w_q_side.neg[l] ? {1'b1, {(SRQ_W-1){1'b0}}} : {1'b0, {(SRQ_W-1){1'b1}}};
            v    = (w_q_ovf[l] || (w_q_quo[l] > lim)) ? lim : w_q_quo[l];
            q[l] = w_q_side.neg[l] ? SRQ_W'(-v) : v;
        end
        if (w_q_side.deg) begin
            p_data.quat_real = $signed(SRQ_W'(1) << OUT_FRAC_BITS);
            p_data.quat_i    = '0;
            p_data.quat_j    = '0;
            p_data.quat_k    = '0;
        end else begin
            p_data.quat_real = $signed(q[0]);
            p_data.quat_i    = $signed(q[1]);
            p_data.quat_j    = $signed(q[2]);
            p_data.quat_k    = $signed(q[3]);
        end
        p_data.degenerate = w_q_side.deg;
    end

    // valid bits of the local stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= w_s_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= w_r_vld;
        end
    end

    // output register with one-word skid
    logic     r_out_vld;
    t_srq_out r_out_data;
    t_srq_out r_skid_data;
    logic     take;

    assign take = !r_out_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (take) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= w_q_vld;
            end
        end else if (en && w_q_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_data <= r_skid_vld ? r_skid_data : p_data;
        end else if (en) begin
            r_skid_data <= p_data;
        end
    end

    assign o_stall = r_skid_vld;
    assign o_valid = r_out_vld;
    assign o_data  = r_out_data;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a word while the output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && i_stall))
        else $error("skid filled without a stalled output");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld && !i_stall |=> !r_skid_vld)
        else $error("skid not drained when output moved");

    a_degenerate_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.degenerate |->
            o_data.quat_i == '0 && o_data.quat_j == '0 && o_data.quat_k == '0)
        else $error("degenerate word with non-zero imaginary part");

endmodule

// ===== rtl/srq_sqrt.sv =====
module srq_sqrt #(
    parameter int VW = 64,
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [VW-1:0]   i_rad,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [VW/2-1:0] o_root,
    output logic [SW-1:0]   o_side
);
    import srq_pkg::*;

    localparam int RW = VW / 2;

    // one root bit per stage, remainder carried down
    logic [VW-1:0] r_rem  [RW-1];
    logic [VW-1:0] n_rem  [RW-1];
    logic [RW-1:0] r_res  [RW];
    logic [RW-1:0] n_res  [RW];
    logic [SW-1:0] r_side [RW];
    logic [SW-1:0] n_side [RW];
    logic [RW-1:0] r_vld;

    function automatic logic [VW+RW-1:0] sq_step(input int b, input logic [VW-1:0] rem,
                                                 input logic [RW-1:0] res);
        logic [VW-1:0] trial;
        logic [VW-1:0] nr;
        logic [RW-1:0] nq;
        trial = (VW'(res) << (b + 1)) | (VW'(1) << (2 * b));
        nr    = rem;
        nq    = res;
        if (rem >= trial) begin
            nr = rem - trial;
            nq = res | (RW'(1) << b);
        end
        return {nr, nq};
    endfunction

    always_comb begin
        logic [VW+RW-1:0] st;
        st        = sq_step(RW - 1, i_rad, '0);
        n_rem[0]  = st[VW+RW-1:RW];
        n_res[0]  = st[RW-1:0];
        n_side[0] = i_side;
        for (int k = 1; k < RW - 1; k++) begin
            st        = sq_step(RW - 1 - k, r_rem[k-1], r_res[k-1]);
            n_rem[k]  = st[VW+RW-1:RW];
            n_res[k]  = st[RW-1:0];
            n_side[k] = r_side[k-1];
        end
        st           = sq_step(0, r_rem[RW-2], r_res[RW-2]);
        n_res[RW-1]  = st[RW-1:0];
        n_side[RW-1] = r_side[RW-2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[RW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_res  <= n_res;
            r_side <= n_side;
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_res[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

// ===== rtl/srq_div.sv =====
module srq_div #(
    parameter int NW = 95,
    parameter int DW = 64,
    parameter int SW = 5
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_en,
    input  logic                                             i_valid,
    input  logic [srq_pkg::SRQ_LANES-1:0][NW-1:0]            i_num,
    input  logic [DW-1:0]                                    i_den,
    input  logic [SW-1:0]                                    i_side,
    output logic                                             o_valid,
    output logic [srq_pkg::SRQ_LANES-1:0][srq_pkg::SRQ_W-1:0] o_quo,
    output logic [srq_pkg::SRQ_LANES-1:0]                    o_ovf,
    output logic [SW-1:0]                                    o_side
);
    import srq_pkg::*;

    localparam int QW = SRQ_W;
    localparam int ST = QW + 1;

    // stage 0 checks for a quotient of 2^32 or more, then one quotient bit per stage;
    // the low numerator bits shift out as quotient bits shift in
    logic [SRQ_LANES-1:0][DW-1:0] r_rem [QW];
    logic [SRQ_LANES-1:0][DW-1:0] n_rem [QW];
    logic [SRQ_LANES-1:0][QW-1:0] r_ql  [ST];
    logic [SRQ_LANES-1:0][QW-1:0] n_ql  [ST];
    logic [DW-1:0]                r_den [QW];
    logic [DW-1:0]                n_den [QW];
    logic [SRQ_LANES-1:0]         r_ovf [ST];
    logic [SRQ_LANES-1:0]         n_ovf [ST];
    logic [SW-1:0]                r_side[ST];
    logic [SW-1:0]                n_side[ST];
    logic [ST-1:0]                r_vld;

    function automatic logic [DW+QW-1:0] div_step(input logic [DW-1:0] rem,
                                                  input logic [QW-1:0] ql,
                                                  input logic [DW-1:0] den);
        logic [DW:0]   t;
        logic          ge;
        logic [DW-1:0] nr;
        t  = {rem, ql[QW-1]};
        ge = t >= {1'b0, den};
        nr = ge ? DW'(t - {1'b0, den}) : t[DW-1:0];
        return {nr, ql[QW-2:0], ge};
    endfunction

    always_comb begin
        logic [DW-1:0]    hi;
        logic [DW+QW-1:0] st;
        hi = '0;
        st = '0;
        for (int l = 0; l < SRQ_LANES; l++) begin
            hi           = DW'(i_num[l][NW-1:QW]);
            n_ovf[0][l]  = hi >= i_den;
            n_rem[0][l]  = n_ovf[0][l] ? '0 : hi;
            n_ql[0][l]   = i_num[l][QW-1:0];
        end
        n_den[0]  = i_den;
        n_side[0] = i_side;
        for (int k = 1; k < QW; k++) begin
            for (int l = 0; l < SRQ_LANES; l++) begin
                st          = div_step(r_rem[k-1][l], r_ql[k-1][l], r_den[k-1]);
                n_rem[k][l] = st[DW+QW-1:QW];
                n_ql[k][l]  = st[QW-1:0];
            end
            n_den[k]  = r_den[k-1];
            n_ovf[k]  = r_ovf[k-1];
            n_side[k] = r_side[k-1];
        end
        for (int l = 0; l < SRQ_LANES; l++) begin
            st           = div_step(r_rem[QW-1][l], r_ql[QW-1][l], r_den[QW-1]);
            n_ql[QW][l]  = st[QW-1:0];
        end
        n_ovf[QW]  = r_ovf[QW-1];
        n_side[QW] = r_side[QW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[ST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_ql   <= n_ql;
            r_den  <= n_den;
            r_ovf  <= n_ovf;
            r_side <= n_side;
        end
    end

    assign o_valid = r_vld[ST-1];
    assign o_quo   = r_ql[ST-1];
    assign o_ovf   = r_ovf[ST-1];
    assign o_side  = r_side[ST-1];

endmodule
